// ----- hw/rtl/satpc_pkg.sv -----
// Package: constants, types and saturating helpers for the SAT collision block.
package satpc_pkg;

	localparam int unsigned DEF_MAX_VERTICES = 16;
	localparam int unsigned DEF_MAX_NORMALS  = 16;
	localparam logic [32:0] SNAP_RESET = 33'd42949673;

	localparam logic [3:0] ACT_VERT_A   = 4'd0;
	localparam logic [3:0] ACT_VERT_B   = 4'd1;
	localparam logic [3:0] ACT_NORM_A   = 4'd2;
	localparam logic [3:0] ACT_NORM_B   = 4'd3;
	localparam logic [3:0] ACT_POS_A    = 4'd4;
	localparam logic [3:0] ACT_OFFSET_A = 4'd5;
	localparam logic [3:0] ACT_POS_B    = 4'd6;
	localparam logic [3:0] ACT_OFFSET_B = 4'd7;
	localparam logic [3:0] ACT_GO       = 4'd8;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	localparam logic signed [63:0] Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;

	function automatic logic signed [63:0] sat65(input logic signed [64:0] v);
		if (v > 65'sd0 && v[64:63] == 2'b01) return Q_MAX;
		if (v[64:63] == 2'b10) return Q_MIN;
		return v[63:0];
	endfunction

	function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
			input logic signed [63:0] b);
		return sat65({a[63], a} + {b[63], b});
	endfunction

	function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
			input logic signed [63:0] b);
		return sat65({a[63], a} - {b[63], b});
	endfunction

	function automatic logic signed [31:0] neg32(input logic signed [31:0] v);
		if (v == 32'sh8000_0000) return 32'sh7FFF_FFFF;
		return -v;
	endfunction

endpackage

// ----- hw/rtl/sat_polygon_collision.sv -----
// Top level: iterative separating-axis collision test of two convex polygons.
// Loads (actions 0..7) are stored while busy is low and do not raise it. A go keeps busy
// high until every axis is tested, or until a separating axis ends the test early, and
// skips the test when it reports an error status. One shared 34x32 multiplier forms
// both products of each dot product, and projections and the separation dot run one
// after another on that unit before gap evaluation. The result appears with done high
// for one cycle as busy falls and cannot be stalled.
module sat_polygon_collision #(
	parameter int unsigned MAX_VERTICES = satpc_pkg::DEF_MAX_VERTICES,
	parameter int unsigned MAX_NORMALS  = satpc_pkg::DEF_MAX_NORMALS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [3:0]         action,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic               cfg_we,
	input  logic [32:0]        cfg_wdata,
	output logic               done,
	output logic               collides,
	output logic signed [63:0] overlap_distance,
	output logic signed [31:0] axis_x,
	output logic signed [31:0] axis_y,
	output logic [1:0]         status
);

	localparam int VW = $clog2(MAX_VERTICES + 1);
	localparam int NW = $clog2(MAX_NORMALS + 1);
	localparam int VI = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int NI = (MAX_NORMALS > 1) ? $clog2(MAX_NORMALS) : 1;
	localparam int AW = NW + 1;

	typedef enum logic [3:0] {
		S_IDLE, S_AXIS, S_AXWAIT, S_VREAD, S_MULX, S_MULY, S_ACC, S_SEPX, S_SEPY,
		S_SEPACC, S_GAP, S_DONE
	} state_t;

	logic [63:0] vert_a_mem [MAX_VERTICES];
	logic [63:0] vert_b_mem [MAX_VERTICES];
	logic [63:0] norm_a_mem [MAX_NORMALS];
	logic [63:0] norm_b_mem [MAX_NORMALS];

	logic [VW-1:0] nva_q, nvb_q;
	logic [NW-1:0] nna_q, nnb_q;
	logic ovf_q;
	logic [32:0] eps_q;
	logic signed [31:0] cax_q, cay_q, oax_q, oay_q, cbx_q, cby_q, obx_q, oby_q;

	state_t state_q;
	logic [AW-1:0] ax_idx_q;
	logic [VW-1:0] v_idx_q;
	logic side_q;
	logic signed [31:0] axx_q, axy_q;
	logic [63:0] na_rd_q, nb_rd_q, va_rd_q, vb_rd_q;
	logic signed [63:0] px_q, prod_q;
	logic signed [63:0] lo1_q, hi1_q, lo2_q, hi2_q, h_q, best_q;
	logic first_q;
	logic signed [31:0] bax_q, bay_q;
	logic signed [33:0] sepx_q, sepy_q;

	logic signed [33:0] sepx_c, sepy_c;
	assign sepx_c = ({{2{cax_q[31]}}, cax_q} + {{2{oax_q[31]}}, oax_q})
		- ({{2{cbx_q[31]}}, cbx_q} + {{2{obx_q[31]}}, obx_q});
	assign sepy_c = ({{2{cay_q[31]}}, cay_q} + {{2{oay_q[31]}}, oay_q})
		- ({{2{cby_q[31]}}, cby_q} + {{2{oby_q[31]}}, oby_q});

	// shared multiplier: axis component times 34-bit operand (vertex or separation)
	logic signed [33:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [65:0] mul_p;
	logic signed [63:0] mul_s;
	always_comb begin
		mul_b = (state_q == S_MULX || state_q == S_SEPX) ? axx_q : axy_q;
		unique case (state_q)
			S_SEPX:  mul_a = sepx_q;
			S_SEPY:  mul_a = sepy_q;
			S_MULX:  mul_a = side_q ? {{2{vb_rd_q[63]}}, vb_rd_q[63:32]}
				: {{2{va_rd_q[63]}}, va_rd_q[63:32]};
			default: mul_a = side_q ? {{2{vb_rd_q[31]}}, vb_rd_q[31:0]}
				: {{2{va_rd_q[31]}}, va_rd_q[31:0]};
		endcase
		mul_p = mul_a * mul_b;
		if (mul_p > 66'sh0_7FFF_FFFF_FFFF_FFFF) mul_s = satpc_pkg::Q_MAX;
		else if (mul_p < -66'sh0_8000_0000_0000_0000) mul_s = satpc_pkg::Q_MIN;
		else mul_s = mul_p[63:0];
	end

	logic signed [63:0] dot_c;
	assign dot_c = satpc_pkg::sadd(px_q, prod_q);

	logic in_acc;
	logic [AW-1:0] naxes;
	logic [VW-1:0] nv_cur;
	assign in_acc = start && !busy;
	assign naxes = {1'b0, nna_q} + {1'b0, nnb_q};
	assign nv_cur = side_q ? nvb_q : nva_q;

	function automatic logic signed [63:0] snapf(input logic signed [63:0] d,
			input logic [32:0] e);
		logic [63:0] m;
		m = d[63] ? (64'd0 - d) : d;
		return ({1'b0, m} < {32'd0, e}) ? 64'sd0 : d;
	endfunction

	logic signed [63:0] d1_c, d2_c, gap_c;
	assign d1_c = snapf(satpc_pkg::ssub(satpc_pkg::sadd(lo1_q, h_q), hi2_q), eps_q);
	assign d2_c = snapf(satpc_pkg::ssub(lo2_q, satpc_pkg::sadd(hi1_q, h_q)), eps_q);
	assign gap_c = (d1_c > d2_c) ? d1_c : d2_c;

	// stores
	always_ff @(posedge clk) begin
		if (in_acc && action == satpc_pkg::ACT_VERT_A && nva_q < VW'(MAX_VERTICES))
			vert_a_mem[nva_q[VI-1:0]] <= {coord_x, coord_y};
		if (in_acc && action == satpc_pkg::ACT_VERT_B && nvb_q < VW'(MAX_VERTICES))
			vert_b_mem[nvb_q[VI-1:0]] <= {coord_x, coord_y};
		if (in_acc && action == satpc_pkg::ACT_NORM_A && nna_q < NW'(MAX_NORMALS))
			norm_a_mem[nna_q[NI-1:0]] <= {coord_x, coord_y};
		if (in_acc && action == satpc_pkg::ACT_NORM_B && nnb_q < NW'(MAX_NORMALS))
			norm_b_mem[nnb_q[NI-1:0]] <= {coord_x, coord_y};
		va_rd_q <= vert_a_mem[v_idx_q[VI-1:0]];
		vb_rd_q <= vert_b_mem[v_idx_q[VI-1:0]];
		na_rd_q <= norm_a_mem[ax_idx_q[NI-1:0]];
		nb_rd_q <= norm_b_mem[NI'(ax_idx_q - AW'(nna_q))];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy <= 1'b0;
			done <= 1'b0;
			nva_q <= '0; nvb_q <= '0; nna_q <= '0; nnb_q <= '0;
			ovf_q <= 1'b0;
			eps_q <= satpc_pkg::SNAP_RESET;
			cax_q <= '0; cay_q <= '0; oax_q <= '0; oay_q <= '0;
			cbx_q <= '0; cby_q <= '0; obx_q <= '0; oby_q <= '0;
			collides <= 1'b0;
			overlap_distance <= '0;
			axis_x <= '0;
			axis_y <= '0;
			status <= satpc_pkg::ST_OK;
		end else begin
			done <= 1'b0;
			if (cfg_we) eps_q <= cfg_wdata;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						case (action)
							satpc_pkg::ACT_VERT_A:
								if (nva_q < VW'(MAX_VERTICES)) nva_q <= nva_q + 1'b1;
								else ovf_q <= 1'b1;
							satpc_pkg::ACT_VERT_B:
								if (nvb_q < VW'(MAX_VERTICES)) nvb_q <= nvb_q + 1'b1;
								else ovf_q <= 1'b1;
							satpc_pkg::ACT_NORM_A:
								if (nna_q < NW'(MAX_NORMALS)) nna_q <= nna_q + 1'b1;
								else ovf_q <= 1'b1;
							satpc_pkg::ACT_NORM_B:
								if (nnb_q < NW'(MAX_NORMALS)) nnb_q <= nnb_q + 1'b1;
								else ovf_q <= 1'b1;
							satpc_pkg::ACT_POS_A: begin cax_q <= coord_x; cay_q <= coord_y; end
							satpc_pkg::ACT_OFFSET_A: begin oax_q <= coord_x; oay_q <= coord_y; end
							satpc_pkg::ACT_POS_B: begin cbx_q <= coord_x; cby_q <= coord_y; end
							satpc_pkg::ACT_OFFSET_B: begin obx_q <= coord_x; oby_q <= coord_y; end
							satpc_pkg::ACT_GO: begin
								busy <= 1'b1;
								ax_idx_q <= '0;
								best_q <= satpc_pkg::Q_MIN;
								bax_q <= '0;
								bay_q <= '0;
								sepx_q <= sepx_c;
								sepy_q <= sepy_c;
								collides <= 1'b0;
								overlap_distance <= '0;
								axis_x <= '0;
								axis_y <= '0;
								if (ovf_q) begin
									status <= satpc_pkg::ST_OVERFLOW;
									state_q <= S_DONE;
								end else if (naxes != '0 && (nva_q == '0 || nvb_q == '0)) begin
									status <= satpc_pkg::ST_EMPTY;
									state_q <= S_DONE;
								end else begin
									status <= satpc_pkg::ST_OK;
									state_q <= S_AXIS;
								end
							end
							default: ;
						endcase
					end
				end
				S_AXIS: begin
					if (ax_idx_q == naxes) begin
						collides <= 1'b1;
						overlap_distance <= best_q;
						axis_x <= bax_q;
						axis_y <= bay_q;
						state_q <= S_DONE;
					end else begin
						state_q <= S_AXWAIT;
					end
				end
				S_AXWAIT: begin
					if (ax_idx_q < AW'(nna_q)) begin
						axx_q <= na_rd_q[63:32]; axy_q <= na_rd_q[31:0];
					end else begin
						axx_q <= nb_rd_q[63:32]; axy_q <= nb_rd_q[31:0];
					end
					side_q <= 1'b0;
					v_idx_q <= '0;
					first_q <= 1'b1;
					state_q <= S_VREAD;
				end
				S_VREAD: state_q <= S_MULX;
				S_MULX: begin px_q <= mul_s; state_q <= S_MULY; end
				S_MULY: begin prod_q <= mul_s; state_q <= S_ACC; end
				S_ACC: begin
					if (!side_q) begin
						if (first_q || dot_c < lo1_q) lo1_q <= dot_c;
						if (first_q || dot_c > hi1_q) hi1_q <= dot_c;
					end else begin
						if (first_q || dot_c < lo2_q) lo2_q <= dot_c;
						if (first_q || dot_c > hi2_q) hi2_q <= dot_c;
					end
					first_q <= 1'b0;
					if (v_idx_q + 1'b1 == nv_cur) begin
						v_idx_q <= '0;
						if (side_q) state_q <= S_SEPX;
						else begin side_q <= 1'b1; first_q <= 1'b1; state_q <= S_VREAD; end
					end else begin
						v_idx_q <= v_idx_q + 1'b1;
						state_q <= S_VREAD;
					end
				end
				S_SEPX: begin px_q <= mul_s; state_q <= S_SEPY; end
				S_SEPY: begin prod_q <= mul_s; state_q <= S_SEPACC; end
				S_SEPACC: begin h_q <= dot_c; state_q <= S_GAP; end
				S_GAP: begin
					if (gap_c > 64'sd0) begin
						overlap_distance <= best_q;
						axis_x <= bax_q;
						axis_y <= bay_q;
						state_q <= S_DONE;
					end else begin
						if (gap_c > best_q) begin
							best_q <= gap_c;
							if (gap_c < 64'sd0 && h_q > 64'sd0) begin
								bax_q <= satpc_pkg::neg32(axx_q);
								bay_q <= satpc_pkg::neg32(axy_q);
							end else begin
								bax_q <= axx_q;
								bay_q <= axy_q;
							end
						end
						ax_idx_q <= ax_idx_q + 1'b1;
						state_q <= S_AXIS;
					end
				end
				S_DONE: begin
					done <= 1'b1;
					busy <= 1'b0;
					nva_q <= '0; nvb_q <= '0; nna_q <= '0; nnb_q <= '0;
					ovf_q <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- dv/sat_polygon_collision_test.sv -----
// Testbench for the SAT collision block: queued request driver, predictor and result monitor.
module sat_polygon_collision_test;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [3:0] act;
		logic [31:0] x;
		logic [31:0] y;
	} request_t;

	typedef struct packed {
		logic coll;
		logic [63:0] odist;
		logic [31:0] ax;
		logic [31:0] ay;
		logic [1:0] st;
	} verdict_t;

	logic clk, arst_n, start, busy, cfg_we, done, collides;
	logic [3:0] action;
	logic signed [31:0] coord_x, coord_y, axis_x, axis_y;
	logic [32:0] cfg_wdata;
	logic signed [63:0] overlap_distance;
	logic [1:0] status;

	sat_polygon_collision DUT (.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .coord_x(coord_x), .coord_y(coord_y), .cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata), .done(done), .collides(collides),
		.overlap_distance(overlap_distance), .axis_x(axis_x), .axis_y(axis_y),
		.status(status));

	request_t pending[$];
	verdict_t verdicts[$];
	int errors = 0;
	int gap_left = 0;

	logic signed [31:0] va_x[16], va_y[16], vb_x[16], vb_y[16];
	logic signed [31:0] na_x[16], na_y[16], nb_x[16], nb_y[16];
	int cnt_va, cnt_vb, cnt_na, cnt_nb;
	logic signed [31:0] pa_x, pa_y, oa_x, oa_y, pb_x, pb_y, ob_x, ob_y;
	bit ovf;
	logic [32:0] eps;

	function automatic logic signed [63:0] sat(input logic signed [65:0] v);
		if (v > 66'sh0_7FFF_FFFF_FFFF_FFFF) return satpc_pkg::Q_MAX;
		if (v < -66'sh0_8000_0000_0000_0000) return satpc_pkg::Q_MIN;
		return v[63:0];
	endfunction

	function automatic logic signed [63:0] proj(input logic signed [31:0] ax,
			input logic signed [31:0] ay, input logic signed [63:0] px,
			input logic signed [63:0] py);
		logic signed [65:0] m1, m2;
		logic signed [63:0] s1, s2;
		m1 = 66'(ax) * 66'(px);
		m2 = 66'(ay) * 66'(py);
		s1 = sat(m1);
		s2 = sat(m2);
		return sat(66'(s1) + 66'(s2));
	endfunction

	function automatic logic signed [63:0] snap(input logic signed [63:0] d);
		logic [64:0] m;
		m = d[63] ? 65'(-66'(d)) : 65'(d);
		return (m < 65'(eps)) ? 64'sd0 : d;
	endfunction

	function automatic logic signed [31:0] flip(input logic signed [31:0] v);
		return (v == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -v;
	endfunction

	function automatic verdict_t collision_verdict();
		verdict_t r;
		logic signed [63:0] best, lo1, hi1, lo2, hi2, d, h, d1, d2, g, sx, sy;
		logic signed [31:0] bx, by, ax, ay;
		int naxes;
		r = '0;
		best = satpc_pkg::Q_MIN; bx = 0; by = 0;
		naxes = cnt_na + cnt_nb;
		if (ovf) begin
			r.st = satpc_pkg::ST_OVERFLOW;
			return r;
		end
		if (naxes > 0 && (cnt_va == 0 || cnt_vb == 0)) begin
			r.st = satpc_pkg::ST_EMPTY;
			return r;
		end
		sx = (64'(pa_x) + 64'(oa_x)) - (64'(pb_x) + 64'(ob_x));
		sy = (64'(pa_y) + 64'(oa_y)) - (64'(pb_y) + 64'(ob_y));
		for (int i = 0; i < naxes; i++) begin
			ax = (i < cnt_na) ? na_x[i] : nb_x[i - cnt_na];
			ay = (i < cnt_na) ? na_y[i] : nb_y[i - cnt_na];
			for (int k = 0; k < cnt_va; k++) begin
				d = proj(ax, ay, 64'(va_x[k]), 64'(va_y[k]));
				if (k == 0 || d < lo1) lo1 = d;
				if (k == 0 || d > hi1) hi1 = d;
			end
			for (int k = 0; k < cnt_vb; k++) begin
				d = proj(ax, ay, 64'(vb_x[k]), 64'(vb_y[k]));
				if (k == 0 || d < lo2) lo2 = d;
				if (k == 0 || d > hi2) hi2 = d;
			end
			h = proj(ax, ay, sx, sy);
			d1 = snap(sat(66'(sat(66'(lo1) + 66'(h))) - 66'(hi2)));
			d2 = snap(sat(66'(lo2) - 66'(sat(66'(hi1) + 66'(h)))));
			g = (d1 > d2) ? d1 : d2;
			if (g > 0) begin
				r.odist = best; r.ax = bx; r.ay = by;
				return r;
			end
			if (g < 0 && h > 0) begin
				ax = flip(ax);
				ay = flip(ay);
			end
			if (g > best) begin
				best = g; bx = ax; by = ay;
			end
		end
		r.coll = 1; r.odist = best; r.ax = bx; r.ay = by;
		return r;
	endfunction

	task automatic apply_request(input request_t q);
		case (q.act)
			satpc_pkg::ACT_VERT_A: if (cnt_va >= 16) ovf = 1;
				else begin va_x[cnt_va] = q.x; va_y[cnt_va] = q.y; cnt_va++; end
			satpc_pkg::ACT_VERT_B: if (cnt_vb >= 16) ovf = 1;
				else begin vb_x[cnt_vb] = q.x; vb_y[cnt_vb] = q.y; cnt_vb++; end
			satpc_pkg::ACT_NORM_A: if (cnt_na >= 16) ovf = 1;
				else begin na_x[cnt_na] = q.x; na_y[cnt_na] = q.y; cnt_na++; end
			satpc_pkg::ACT_NORM_B: if (cnt_nb >= 16) ovf = 1;
				else begin nb_x[cnt_nb] = q.x; nb_y[cnt_nb] = q.y; cnt_nb++; end
			satpc_pkg::ACT_POS_A: begin pa_x = q.x; pa_y = q.y; end
			satpc_pkg::ACT_OFFSET_A: begin oa_x = q.x; oa_y = q.y; end
			satpc_pkg::ACT_POS_B: begin pb_x = q.x; pb_y = q.y; end
			satpc_pkg::ACT_OFFSET_B: begin ob_x = q.x; ob_y = q.y; end
			satpc_pkg::ACT_GO: begin
				verdicts.insert(verdicts.size(), collision_verdict());
				cnt_va = 0; cnt_vb = 0; cnt_na = 0; cnt_nb = 0; ovf = 0;
			end
			default: ;
		endcase
	endtask

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// driver
	always @(posedge clk) begin
		if (start && !busy) begin
			apply_request(pending.pop_front());
			gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
			if (pending.size() > 0 && $urandom_range(0, 3) == 0) begin
				action <= pending[0].act; coord_x <= pending[0].x; coord_y <= pending[0].y;
			end else
				start <= 0;
		end else if (!start && pending.size() > 0 && arst_n && !cfg_we) begin
			if (gap_left > 0)
				gap_left <= gap_left - 1;
			else begin
				start <= 1;
				action <= pending[0].act; coord_x <= pending[0].x; coord_y <= pending[0].y;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (done) begin
			if (verdicts.size() == 0) begin
				$error("unexpected result");
				errors++;
			end else begin
				verdict_t e;
				e = verdicts.pop_front();
				if (collides !== e.coll) begin
					$error("collides exp %0d got %0d", e.coll, collides); errors++; end
				if (overlap_distance !== e.odist) begin
					$error("overlap_distance exp %h got %h", e.odist, overlap_distance);
					errors++; end
				if (axis_x !== e.ax) begin
					$error("axis_x exp %h got %h", e.ax, axis_x); errors++; end
				if (axis_y !== e.ay) begin
					$error("axis_y exp %h got %h", e.ay, axis_y); errors++; end
				if (status !== e.st) begin
					$error("status exp %0d got %0d", e.st, status); errors++; end
			end
		end
	end

	function automatic logic [31:0] rand_coord(input int mode);
		case (mode)
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
			2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			default: return 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
		endcase
	endfunction

	task automatic push(input logic [3:0] a, input logic [31:0] x, input logic [31:0] y);
		request_t q;
		q.act = a; q.x = x; q.y = y;
		pending.insert(pending.size(), q);
	endtask

	task automatic push_scene(input int nva, input int nvb, input int nna, input int nnb,
			input int mode);
		for (int i = 0; i < nva; i++)
			push(satpc_pkg::ACT_VERT_A, rand_coord(mode), rand_coord(mode));
		for (int i = 0; i < nvb; i++)
			push(satpc_pkg::ACT_VERT_B, rand_coord(mode), rand_coord(mode));
		for (int i = 0; i < nna; i++)
			push(satpc_pkg::ACT_NORM_A, rand_coord(mode), rand_coord(mode));
		for (int i = 0; i < nnb; i++)
			push(satpc_pkg::ACT_NORM_B, rand_coord(mode), rand_coord(mode));
		push(satpc_pkg::ACT_POS_A, rand_coord(mode), rand_coord(mode));
		push(satpc_pkg::ACT_OFFSET_A, rand_coord(3), rand_coord(3));
		push(satpc_pkg::ACT_POS_B, rand_coord(mode), rand_coord(mode));
		push(satpc_pkg::ACT_OFFSET_B, rand_coord(3), rand_coord(3));
		push(satpc_pkg::ACT_GO, rand_coord(0), rand_coord(0));
	endtask

	task automatic drain();
		while (pending.size() > 0 || start || verdicts.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_eps(input logic [32:0] v);
		cfg_we <= 1; cfg_wdata <= v;
		@(posedge clk);
		eps = v;
		cfg_we <= 0;
		@(posedge clk);
	endtask

	initial begin
		int sent;
		logic [32:0] eps_set[4];
		eps_set[0] = 33'd0;
		eps_set[1] = 33'h1_0000_0000;
		eps_set[2] = 33'h1_FFFF_FFFF;
		eps_set[3] = satpc_pkg::SNAP_RESET;
		arst_n = 0; start = 0; action = 0; coord_x = 0; coord_y = 0;
		cfg_we = 0; cfg_wdata = 0;
		cnt_va = 0; cnt_vb = 0; cnt_na = 0; cnt_nb = 0; ovf = 0;
		pa_x = 0; pa_y = 0; oa_x = 0; oa_y = 0; pb_x = 0; pb_y = 0; ob_x = 0; ob_y = 0;
		eps = satpc_pkg::SNAP_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: no axes, empty vertices, overflow, extremes, unused actions
		push(satpc_pkg::ACT_GO, 0, 0);
		push(satpc_pkg::ACT_NORM_A, 32'h0001_0000, 0);
		push(satpc_pkg::ACT_GO, 0, 0);
		for (int i = 0; i < 17; i++) push(satpc_pkg::ACT_VERT_A, i, i);
		push(satpc_pkg::ACT_GO, 0, 0);
		push(4'd9, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push(4'd15, 0, 0);
		push_scene(2, 2, 1, 1, 2);
		push(satpc_pkg::ACT_VERT_A, 32'h8000_0000, 32'h8000_0000);
		push(satpc_pkg::ACT_VERT_B, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		push(satpc_pkg::ACT_NORM_B, 32'h8000_0000, 32'h8000_0000);
		push(satpc_pkg::ACT_GO, 0, 0);
		drain();
		sent = 0;
		for (int ph = 0; ph < 4; ph++) begin
			write_eps(ph == 3 ? 33'($urandom) : eps_set[ph]);
			while (sent < (ph + 1) * 380) begin
				int r, nva, nvb, qlen;
				r = $urandom_range(0, 19);
				nva = $urandom_range(0, 7) == 0 ? $urandom_range(0, 17) : $urandom_range(1, 4);
				nvb = $urandom_range(0, 7) == 0 ? $urandom_range(0, 17) : $urandom_range(1, 4);
				if (r == 0) begin
					push(4'($urandom_range(0, 15)), $urandom, $urandom);
					sent++;
				end else begin
					qlen = pending.size();
					push_scene(nva, nvb, $urandom_range(0, 3), $urandom_range(0, 3),
						$urandom_range(0, 3));
					sent += pending.size() - qlen;
					drain();
				end
			end
			drain();
		end
		write_eps(eps_set[3]);
		push_scene(3, 3, 2, 2, 3);
		drain();
		if (errors == 0 && verdicts.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#50ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/satpc_pkg.sv
hw/rtl/sat_polygon_collision.sv
dv/sat_polygon_collision_test.sv
